// ----- src/etu_pkg.sv -----
// Shared constants and types for the epoch seconds to UTC date and time converter.
package etu_pkg;

  localparam int DivW  = 32;
  localparam int DvsW  = 21;
  localparam int MagW  = 23;
  localparam int ShW   = 6;
  localparam int ProdW = DivW + MagW;

  localparam logic [63:0] SecMin     = 64'hFFFF_FFF1_886E_0900; // -62135596800
  localparam logic [63:0] SecMax     = 64'd253402300799;
  localparam logic [38:0] SecToYear1 = 39'd62135596800;
  localparam logic [22:0] DayOffset  = 23'd1789995;

  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatLow  = 2'd1;
  localparam logic [1:0] StatHigh = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DAY, ST_HOUR, ST_MIN, ST_MIN2, ST_N, ST_I, ST_J, ST_K, ST_L, ST_FRAC, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    DV_IDLE, DV_EST, DV_BACK, DV_FIX
  } div_state_t;

  typedef struct packed {
    logic [DivW-1:0] dividend;
    logic [DvsW-1:0] divisor;
    logic [MagW-1:0] magic;
    logic [ShW-1:0]  shift;
  } div_req_t;

endpackage

// ----- src/etu_div.sv -----
// Shared divide-by-constant unit built on one multiplier: reciprocal estimate, multiply back, correct.
module etu_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  etu_pkg::div_req_t           req,
  output logic                        done,
  output logic [etu_pkg::DivW-1:0]    quotient,
  output logic [etu_pkg::DvsW-1:0]    remainder
);

  etu_pkg::div_state_t         dstate, dstate_next;
  logic [etu_pkg::DivW-1:0]    dvd;
  logic [etu_pkg::DvsW-1:0]    dvs;
  logic [etu_pkg::MagW-1:0]    mag;
  logic [etu_pkg::ShW-1:0]     sh;
  logic [etu_pkg::DivW-1:0]    est;
  logic [etu_pkg::DivW-1:0]    rest;
  logic [etu_pkg::DivW-1:0]    mul_a;
  logic [etu_pkg::MagW-1:0]    mul_b;
  logic [etu_pkg::ProdW-1:0]   prod;
  logic                        fits;

  // The magic value is the floor of two to the shift over the divisor, and the dividend is
  // below two to the shift, so the estimate is the quotient or one less.
  assign prod = etu_pkg::ProdW'(mul_a) * etu_pkg::ProdW'(mul_b);
  assign fits = rest >= etu_pkg::DivW'(dvs);

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= etu_pkg::DV_IDLE;
    end else begin
      dstate <= dstate_next;
    end
  end

  always_comb begin
    dstate_next = dstate;
    mul_a       = est;
    mul_b       = etu_pkg::MagW'(dvs);
    unique case (dstate)
      etu_pkg::DV_IDLE: begin
        if (start) begin
          dstate_next = etu_pkg::DV_EST;
        end
      end
      etu_pkg::DV_EST: begin
        mul_a       = dvd;
        mul_b       = mag;
        dstate_next = etu_pkg::DV_BACK;
      end
      etu_pkg::DV_BACK: dstate_next = etu_pkg::DV_FIX;
      etu_pkg::DV_FIX:  dstate_next = etu_pkg::DV_IDLE;
      default:          dstate_next = etu_pkg::DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (dstate)
        etu_pkg::DV_IDLE: begin
          if (start) begin
            dvd <= req.dividend;
            dvs <= req.divisor;
            mag <= req.magic;
            sh  <= req.shift;
          end
        end
        etu_pkg::DV_EST: est <= etu_pkg::DivW'(prod >> sh);
        etu_pkg::DV_BACK: rest <= dvd - prod[etu_pkg::DivW-1:0];
        etu_pkg::DV_FIX: begin
          done <= 1'b1;
          if (fits) begin
            quotient  <= est + etu_pkg::DivW'(1);
            remainder <= etu_pkg::DvsW'(rest - etu_pkg::DivW'(dvs));
          end else begin
            quotient  <= est;
            remainder <= rest[etu_pkg::DvsW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- src/epoch_seconds_to_utc_datetime.sv -----
// Top level of the epoch seconds to UTC calendar date and time converter.
// The block takes one beat at a time and is not ready again until its result beat has been
// accepted. Every division is by a constant and runs through one shared unit that multiplies
// by a reciprocal, multiplies back and corrects once. Nine divisions give the date and time
// of day. Nonzero nanos add one division per trimmed group of three zeros plus a final one,
// up to four in all. Out-of-range seconds skip the divisions and give a result in the cycle
// after acceptance.
module epoch_seconds_to_utc_datetime (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,  // seconds[63:0], nanos[95:64]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata   // status, year, month, day, hour, minute, second,
                                // has_fraction, fraction_value, fraction_digits, pad
);

  etu_pkg::state_t state, state_next;
  logic launched, launched_next;
  logic div_start, div_done;
  etu_pkg::div_req_t req;
  logic [etu_pkg::DivW-1:0] q;
  logic [etu_pkg::DvsW-1:0] r;

  logic [38:0] sp;
  logic [16:0] rem;
  logic [10:0] mtot;
  logic [22:0] l;
  logic [7:0]  n;
  logic [9:0]  i;
  logic [6:0]  j;
  logic [1:0]  status;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic        has_fraction;
  logic [31:0] fraction_value;
  logic [3:0]  fraction_digits;

  logic [63:0] sec_in;
  logic [31:0] nanos_in;
  logic        too_low, too_high;

  assign sec_in   = s_tdata[63:0];
  assign nanos_in = s_tdata[95:64];
  assign too_low  = $signed(sec_in) < $signed(etu_pkg::SecMin);
  assign too_high = $signed(sec_in) > $signed(etu_pkg::SecMax);

  assign s_tready = state == etu_pkg::ST_IDLE;
  assign m_tvalid = state == etu_pkg::ST_OUT;
  assign m_tdata  = {1'b0, fraction_digits, fraction_value, has_fraction, second, minute,
                     hour, day, month, year, status};

  etu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .req       (req),
    .done      (div_done),
    .quotient  (q),
    .remainder (r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= etu_pkg::ST_IDLE;
      launched <= 1'b0;
    end else begin
      state    <= state_next;
      launched <= launched_next;
    end
  end

  always_comb begin
    state_next    = state;
    launched_next = launched;
    div_start     = 1'b0;
    req           = '0;
    unique case (state)
      etu_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (too_low || too_high) ? etu_pkg::ST_OUT : etu_pkg::ST_DAY;
        end
      end
      etu_pkg::ST_DAY: req = '{sp[38:7], 21'd675, 23'd6362914, 6'd32};
      etu_pkg::ST_HOUR: req = '{32'(rem), 21'd3600, 23'd36, 6'd17};
      etu_pkg::ST_MIN: req = '{32'(rem), 21'd60, 23'd2184, 6'd17};
      etu_pkg::ST_MIN2: req = '{32'(mtot), 21'd60, 23'd34, 6'd11};
      etu_pkg::ST_N: req = '{32'({l, 2'b00}), 21'd146097, 23'd229, 6'd25};
      etu_pkg::ST_I: req = '{(32'(l) + 32'd1) * 32'd4000, 21'd1461001, 23'd183, 6'd28};
      etu_pkg::ST_J: req = '{32'(l) * 32'd80, 21'd2447, 23'd26, 6'd16};
      etu_pkg::ST_K: req = '{32'(j) * 32'd2447, 21'd80, 23'd819, 6'd16};
      etu_pkg::ST_L: req = '{32'(j), 21'd11, 23'd11, 6'd7};
      etu_pkg::ST_FRAC: req = '{fraction_value, 21'd1000, 23'd4294967, 6'd32};
      etu_pkg::ST_OUT: begin
        if (m_tready) begin
          state_next = etu_pkg::ST_IDLE;
        end
      end
      default: state_next = etu_pkg::ST_IDLE;
    endcase
    if (state != etu_pkg::ST_IDLE && state != etu_pkg::ST_OUT) begin
      if (state == etu_pkg::ST_FRAC && !has_fraction) begin
        state_next = etu_pkg::ST_OUT;
      end else if (!launched) begin
        div_start     = 1'b1;
        launched_next = 1'b1;
      end else if (div_done) begin
        launched_next = 1'b0;
        unique case (state)
          etu_pkg::ST_DAY:  state_next = etu_pkg::ST_HOUR;
          etu_pkg::ST_HOUR: state_next = etu_pkg::ST_MIN;
          etu_pkg::ST_MIN:  state_next = etu_pkg::ST_MIN2;
          etu_pkg::ST_MIN2: state_next = etu_pkg::ST_N;
          etu_pkg::ST_N:    state_next = etu_pkg::ST_I;
          etu_pkg::ST_I:    state_next = etu_pkg::ST_J;
          etu_pkg::ST_J:    state_next = etu_pkg::ST_K;
          etu_pkg::ST_K:    state_next = etu_pkg::ST_L;
          etu_pkg::ST_L:    state_next = etu_pkg::ST_FRAC;
          default:          state_next = (r == '0) ? etu_pkg::ST_FRAC : etu_pkg::ST_OUT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == etu_pkg::ST_IDLE && s_tvalid) begin
      status          <= too_low ? etu_pkg::StatLow :
                         (too_high ? etu_pkg::StatHigh : etu_pkg::StatOk);
      sp              <= sec_in[38:0] + etu_pkg::SecToYear1;
      year            <= '0;
      month           <= '0;
      day             <= '0;
      hour            <= '0;
      minute          <= '0;
      second          <= '0;
      has_fraction    <= 1'b0;
      fraction_value  <= '0;
      fraction_digits <= '0;
      if (!too_low && !too_high && nanos_in != '0) begin
        has_fraction    <= 1'b1;
        fraction_value  <= nanos_in[31] ? 32'(~nanos_in + 32'd1) : nanos_in;
        fraction_digits <= 4'd9;
      end
    end else if (launched && div_done) begin
      unique case (state)
        etu_pkg::ST_DAY: begin
          l   <= 23'(q) + etu_pkg::DayOffset;
          rem <= {r[9:0], sp[6:0]};
        end
        etu_pkg::ST_HOUR: hour <= q[4:0];
        etu_pkg::ST_MIN: begin
          second <= r[5:0];
          mtot   <= q[10:0];
        end
        etu_pkg::ST_MIN2: minute <= r[5:0];
        etu_pkg::ST_N: begin
          n <= q[7:0];
          l <= l - 23'((26'd146097 * 26'(q[7:0]) + 26'd3) >> 2);
        end
        etu_pkg::ST_I: begin
          i <= q[9:0];
          l <= l - 23'((23'd1461 * 23'(q[9:0])) >> 2) + 23'd31;
        end
        etu_pkg::ST_J: j <= q[6:0];
        etu_pkg::ST_K: day <= 5'(l - 23'(q[15:0]));
        etu_pkg::ST_L: begin
          month <= 4'(8'(j) + 8'd2 - 8'(8'd12 * 8'(q[3:0])));
          year  <= 14'(16'(16'd100 * (16'(n) - 16'd49)) + 16'(i) + 16'(q[3:0]));
        end
        default: begin
          if (r == '0) begin
            fraction_value  <= q;
            fraction_digits <= fraction_digits - 4'd3;
          end
        end
      endcase
    end
  end

endmodule

// ----- src/etu_checker.sv -----
// Port-level assertions for the epoch seconds to UTC date and time converter.
module etu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("ready right after a beat");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != etu_pkg::StatOk) |-> (m_tdata[79:2] == '0))
    else $error("error result carries data");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == etu_pkg::StatOk) |->
    (m_tdata[19:16] != 4'd0 && m_tdata[19:16] <= 4'd12 && m_tdata[24:20] != 5'd0))
    else $error("month or day out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind epoch_seconds_to_utc_datetime etu_checker u_etu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- bench/tb_top.sv -----
// Testbench for the epoch seconds to UTC date and time converter, checked against a predictor.
`timescale 1ns / 100ps

module tb_top;

  localparam int NumItems  = 1900;
  localparam int CalmItems = 150;
  localparam longint CycleLimit = 3000000;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        has_fraction;
    logic [31:0] fraction_value;
    logic [3:0]  fraction_digits;
  } utc_time_t;

  class utc_scoreboard;
    utc_time_t pending[$];
    int errors = 0;

    function utc_time_t convert(logic [63:0] secs, logic [31:0] nanos);
      utc_time_t r;
      logic [63:0] s;
      logic [31:0] frac;
      longint days, l, n, i, j, k;
      logic [3:0] digits;
      r = '0;
      if ($signed(secs) < $signed(etu_pkg::SecMin)) begin
        r.status = etu_pkg::StatLow;
        return r;
      end
      if ($signed(secs) > $signed(etu_pkg::SecMax)) begin
        r.status = etu_pkg::StatHigh;
        return r;
      end
      r.status = etu_pkg::StatOk;
      s = secs + 64'd62135596800;
      days = longint'(s / 64'd86400);
      l = days - 719162 + 68569 + 2440588;
      n = (4 * l) / 146097;
      l = l - (146097 * n + 3) / 4;
      i = (4000 * (l + 1)) / 1461001;
      l = l - (1461 * i) / 4 + 31;
      j = (80 * l) / 2447;
      k = l - (2447 * j) / 80;
      l = j / 11;
      j = j + 2 - 12 * l;
      i = 100 * (n - 49) + i + l;
      r.year   = i[13:0];
      r.month  = j[3:0];
      r.day    = k[4:0];
      r.hour   = 5'((s / 64'd3600) % 64'd24);
      r.minute = 6'((s / 64'd60) % 64'd60);
      r.second = 6'(s % 64'd60);
      if (nanos != 0) begin
        frac = nanos[31] ? (~nanos) + 32'd1 : nanos;
        digits = 4'd9;
        while (frac % 32'd1000 == 0) begin
          frac = frac / 32'd1000;
          digits = digits - 4'd3;
        end
        r.has_fraction = 1'b1;
        r.fraction_value = frac;
        r.fraction_digits = digits;
      end
      return r;
    endfunction

    function void note(logic [63:0] secs, logic [31:0] nanos);
      pending.insert(pending.size(), convert(secs, nanos));
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check(logic [79:0] d);
      utc_time_t w;
      if (pending.size() == 0) begin
        report("unexpected beat", d[63:0], 64'd0);
        return;
      end
      w = pending.pop_front();
      if (d[1:0] != w.status) report("status", 64'(d[1:0]), 64'(w.status));
      if (d[15:2] != w.year) report("year", 64'(d[15:2]), 64'(w.year));
      if (d[19:16] != w.month) report("month", 64'(d[19:16]), 64'(w.month));
      if (d[24:20] != w.day) report("day", 64'(d[24:20]), 64'(w.day));
      if (d[29:25] != w.hour) report("hour", 64'(d[29:25]), 64'(w.hour));
      if (d[35:30] != w.minute) report("minute", 64'(d[35:30]), 64'(w.minute));
      if (d[41:36] != w.second) report("second", 64'(d[41:36]), 64'(w.second));
      if (d[42] != w.has_fraction) begin
        report("has_fraction", 64'(d[42]), 64'(w.has_fraction));
      end
      if (d[74:43] != w.fraction_value) begin
        report("fraction_value", 64'(d[74:43]), 64'(w.fraction_value));
      end
      if (d[78:75] != w.fraction_digits) begin
        report("fraction_digits", 64'(d[78:75]), 64'(w.fraction_digits));
      end
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [79:0] m_tdata;

  utc_scoreboard sb = new();
  bit calm = 0;
  longint cycles = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  epoch_seconds_to_utc_datetime u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task send_beat(logic [63:0] secs, logic [31:0] nanos);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {nanos, secs};
    do @(posedge clk); while (!s_tready);
    sb.note(secs, nanos);
  endtask

  function automatic logic [31:0] pick_nanos();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom;
      2: return 32'($urandom_range(1, 999999)) * 32'd1000;
      3: return 32'($urandom_range(1, 999)) * 32'd1000000;
      4: return -32'($urandom_range(1, 999999999));
      default: return 32'($urandom_range(0, 999999999));
    endcase
  endfunction

  function automatic logic [63:0] pick_seconds();
    logic [63:0] r;
    logic [63:0] span;
    span = etu_pkg::SecMax - etu_pkg::SecMin + 64'd1;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return r;
      1: return etu_pkg::SecMin + 64'($urandom_range(0, 200)) - 64'd100;
      2: return etu_pkg::SecMax + 64'($urandom_range(0, 200)) - 64'd100;
      3: return 64'($signed(32'($urandom_range(0, 200000)) - 32'sd100000));
      default: return etu_pkg::SecMin + (r % span);
    endcase
  endfunction

  initial begin
    logic [63:0] dsec[$];
    logic [31:0] dnan[$];
    int stall;
    dsec = '{etu_pkg::SecMin, etu_pkg::SecMin - 64'd1, etu_pkg::SecMax,
             etu_pkg::SecMax + 64'd1, 64'd0, '1,
             64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'd951782400,
             64'd4107542400, 64'd86399, 64'd1709164800, 64'd0, 64'd0, 64'd0,
             64'd0, 64'd0, 64'd0, 64'd0, 64'd0};
    dnan = '{32'd0, 32'd5, 32'd999999999, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF,
             32'd1000, 32'd1000000, 32'd123456789, 32'd0, 32'd7000, 32'd0,
             32'd1000000000, -32'd1000000000, 32'd2000000000, -32'd2000000000,
             32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, -32'd5000000};
    fork
      forever begin
        @(posedge clk);
        if (m_tvalid && m_tready) sb.check(m_tdata);
        if (stall > 0) begin
          stall--;
          m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          stall = $urandom_range(0, 17);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    join_none
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (dsec[x]) send_beat(dsec[x], dnan[x]);
    for (int x = 0; x < NumItems; x++) begin
      if (x == NumItems - CalmItems) calm = 1;
      send_beat(pick_seconds(), pick_nanos());
    end
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ----- files.f -----
src/etu_pkg.sv
src/etu_div.sv
src/epoch_seconds_to_utc_datetime.sv
src/etu_checker.sv
bench/tb_top.sv
